FILE: hdl/cdw_pkg.sv
// Package: shared widths, register codes and types of the chunk DMA window core.
`timescale 1ns / 1ps
`default_nettype none

package cdw_pkg;

	localparam int ITER_W    = 16;
	localparam int IDX_W     = 17;  // first chunk plus iteration
	localparam int CNT_W     = 16;
	localparam int LINES_W   = 17;
	localparam int LEN_W     = 32;
	localparam int OFF_W     = 32;
	localparam int OVL_W     = 12;
	localparam int LP_W      = 33;  // line length before rounding
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 3;

	// radix-2 restoring divider: dividend padded to a whole number of stages
	localparam int DIV_N_W   = 18;
	localparam int DIV_STEPS = 6;

	localparam logic [31:0]      GRID_RESET = 32'h0001_0001;
	localparam logic [OFF_W-1:0] OFF_MAX    = 32'h7FFF_FFFF;
	localparam logic [OFF_W-1:0] OFF_MIN    = 32'h8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID    = 3'd0,
		REG_FIRST   = 3'd1,
		REG_TILE    = 3'd2,
		REG_EDGE    = 3'd3,
		REG_STRIDE  = 3'd4,
		REG_OVERLAP = 3'd5,
		REG_MODE    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0] quo;
		logic [CNT_W-1:0] rem;
	} div_res_t;

endpackage

`default_nettype wire

FILE: hdl/cdw_ifs.sv
// Interfaces: iteration input channel and DMA window result channel.
`timescale 1ns / 1ps
`default_nettype none

interface cdw_iter_if;
	import cdw_pkg::*;
	logic              valid;
	logic              ready;
	logic [ITER_W-1:0] iteration;
	modport source (output valid, output iteration, input ready);
	modport sink   (input valid, input iteration, output ready);
endinterface

interface cdw_win_if;
	import cdw_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [LINES_W-1:0]       line_count;
	logic [LEN_W-1:0]         line_length;
	logic signed [OFF_W-1:0]  byte_offset;
	modport source (output valid, output line_count, output line_length,
		output byte_offset, input ready);
	modport sink   (input valid, input line_count, input line_length,
		input byte_offset, output ready);
endinterface

`default_nettype wire

FILE: hdl/cdw_div.sv
// Three-stage pipelined restoring divider: chunk index into row and column index.
`timescale 1ns / 1ps
`default_nettype none

module cdw_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [cdw_pkg::IDX_W-1:0]   dividend,
	input  logic [cdw_pkg::CNT_W-1:0]   divisor,
	output logic                        out_valid,
	input  logic                        out_ready,
	output cdw_pkg::div_res_t           res
);
	import cdw_pkg::*;

	typedef struct packed {
		logic [CNT_W-1:0]   rem;
		logic [DIV_N_W-1:0] nq;  // dividend bits shifting out, quotient bits shifting in
	} div_state_t;

	function automatic div_state_t div_steps(input div_state_t st, input logic [CNT_W-1:0] d);
		div_state_t       r;
		logic [CNT_W:0]   t;
		logic             ge;
		r = st;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t    = {r.rem, r.nq[DIV_N_W-1]};
			ge   = (t >= {1'b0, d});
			r.nq = {r.nq[DIV_N_W-2:0], ge};
			if (ge) begin
				r.rem = CNT_W'(t - {1'b0, d});
			end else begin
				r.rem = t[CNT_W-1:0];
			end
		end
		return r;
	endfunction

	div_state_t st_in;
	div_state_t st_s1, st_s2, st_s3;
	logic       v_s1, v_s2, v_s3;
	logic       en1, en2, en3;

	assign st_in.rem = '0;
	assign st_in.nq  = DIV_N_W'(dividend);

	// a stage moves when it is empty or its successor moves
	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) st_s1 <= div_steps(st_in, divisor);
		if (en2) st_s2 <= div_steps(st_s1, divisor);
		if (en3) st_s3 <= div_steps(st_s2, divisor);
	end

	assign out_valid = v_s3;
	assign res.quo   = st_s3.nq[IDX_W-1:0];
	assign res.rem   = st_s3.rem;

endmodule

`default_nettype wire

FILE: hdl/chunk_dma_window_core.sv
// Top level: DMA window of one chunk of a tiled 2-D or folded 3-D view.
//
// Each transfer on iter carries an iteration number; after nine pipeline stages a transfer on
// win returns its window: line count, line length in elements (rounded up to a multiple of
// DMA_ALIGN_ELEMENTS and saturated) and the signed byte offset saturated to 32 bits. One
// window per clock is sustained while win is ready. Stages one to three are the row/column
// divider (six quotient bits each); stages four to nine hold the 33x24 and 32x24 offset
// products, the overlap rounding by reciprocal multiply, the offset sum and saturation, and
// the final line length rounding. A stall on win holds results in place and empty stages
// still take new items. Configuration writes are taken at any time but must only be issued
// while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module chunk_dma_window_core #(
	parameter int DMA_ALIGN_ELEMENTS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cdw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cdw_pkg::CFG_W-1:0]       cfg_data,
	cdw_iter_if.sink                        iter,
	cdw_win_if.source                       win
);
	import cdw_pkg::*;

	localparam int ALN_W   = $clog2(DMA_ALIGN_ELEMENTS + 1);
	localparam logic [ALN_W-1:0] ALN = ALN_W'(DMA_ALIGN_ELEMENTS);
	// overlap rounding: floor(x / A) as (x * M_OV) >> K_OV, exact for 12-bit x
	localparam int K_OV    = OVL_W + ALN_W;
	localparam int M_OV_W  = K_OV + 1;
	localparam logic [M_OV_W-1:0] M_OV =
		M_OV_W'(((longint'(1) << K_OV) + DMA_ALIGN_ELEMENTS - 1) / DMA_ALIGN_ELEMENTS);
	localparam int RND_W   = OVL_W + 1;
	// line length residue: fold the top bits with 2^16 mod A, then reciprocal multiply
	localparam logic [ALN_W-1:0] C16 = ALN_W'((longint'(1) << 16) % DMA_ALIGN_ELEMENTS);
	localparam int XF_W    = LP_W - 16 + ALN_W + 1;
	localparam int K_XF    = XF_W + ALN_W;
	localparam int M_XF_W  = K_XF + 1;
	localparam logic [M_XF_W-1:0] M_XF =
		M_XF_W'(((longint'(1) << K_XF) + DMA_ALIGN_ELEMENTS - 1) / DMA_ALIGN_ELEMENTS);
	localparam logic [LEN_W-1:0] LEN_MAX =
		LEN_W'((64'd4294967295 / DMA_ALIGN_ELEMENTS) * DMA_ALIGN_ELEMENTS);

	// configuration registers
	logic [31:0] grid_q;
	logic [15:0] first_q;
	logic [47:0] tile_q;
	logic [31:0] edge_q;
	logic [47:0] stride_q;
	logic [47:0] ovl_q;
	logic [8:0]  mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q   <= GRID_RESET;
			first_q  <= '0;
			tile_q   <= '0;
			edge_q   <= '0;
			stride_q <= '0;
			ovl_q    <= '0;
			mode_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GRID:    grid_q   <= cfg_data[31:0];
				REG_FIRST:   first_q  <= cfg_data[15:0];
				REG_TILE:    tile_q   <= cfg_data[47:0];
				REG_EDGE:    edge_q   <= cfg_data[31:0];
				REG_STRIDE:  stride_q <= cfg_data[47:0];
				REG_OVERLAP: ovl_q    <= cfg_data[47:0];
				REG_MODE:    mode_q   <= cfg_data[8:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	logic [CNT_W-1:0] n0, n1, n1e, s0, s1, s2, e0, e1;
	logic [23:0]      st0, st1;
	logic [OVL_W-1:0] lead0, trail0, lead1, trail1;
	logic             fold, skip_f0, skip_l0, skip_f1, skip_l1;
	logic [3:0]       shift;

	assign n0      = grid_q[31:16];
	assign n1      = grid_q[15:0];
	assign n1e     = (n1 == '0) ? CNT_W'(1) : n1;
	assign s0      = tile_q[47:32];
	assign s1      = tile_q[31:16];
	assign s2      = tile_q[15:0];
	assign e0      = edge_q[31:16];
	assign e1      = edge_q[15:0];
	assign st0     = stride_q[47:24];
	assign st1     = stride_q[23:0];
	assign lead0   = ovl_q[47:36];
	assign trail0  = ovl_q[35:24];
	assign lead1   = ovl_q[23:12];
	assign trail1  = ovl_q[11:0];
	assign fold    = mode_q[0];
	assign skip_f0 = mode_q[1];
	assign skip_l0 = mode_q[2];
	assign skip_f1 = mode_q[3];
	assign skip_l1 = mode_q[4];
	assign shift   = mode_q[8:5];

	// stages one to three: divider
	logic             div_vld, div_rdy;
	div_res_t         div_res;
	logic [IDX_W-1:0] idx;

	assign idx = IDX_W'(first_q) + IDX_W'(iter.iteration);

	cdw_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (iter.valid),
		.in_ready  (iter.ready),
		.dividend  (idx),
		.divisor   (n1e),
		.out_valid (div_vld),
		.out_ready (div_rdy),
		.res       (div_res)
	);

	logic v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic en4, en5, en6, en7, en8, en9;

	assign en9     = !v_s9 || win.ready;
	assign en8     = !v_s8 || en9;
	assign en7     = !v_s7 || en8;
	assign en6     = !v_s6 || en7;
	assign en5     = !v_s5 || en6;
	assign en4     = !v_s4 || en5;
	assign div_rdy = en4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en4) v_s4 <= div_vld;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
			if (en9) v_s9 <= v_s8;
		end
	end

	// stage four: edge flags, line count, first products
	logic [IDX_W-1:0]          idx0;
	logic [CNT_W-1:0]          idx1;
	logic                      last0_c, last1_c;
	logic                      lead0_en_c, trail0_en_c, lead1_en_c, trail1_en_c;
	logic [LINES_W-1:0]        lines_c;
	logic [OVL_W+M_OV_W-1:0]   pql_c, pqt_c;

	assign idx0        = div_res.quo;
	assign idx1        = div_res.rem;
	assign last0_c     = (n0 != '0) && (idx0 == IDX_W'(n0) - IDX_W'(1));
	assign last1_c     = (idx1 == n1e - CNT_W'(1));
	assign lead0_en_c  = (lead0 != '0) && ((idx0 != '0) || !skip_f0);
	assign trail0_en_c = (trail0 != '0) && (!last0_c || !skip_l0);
	assign lead1_en_c  = (lead1 != '0) && ((idx1 != '0) || !skip_f1);
	assign trail1_en_c = (trail1 != '0) && (!last1_c || !skip_l1);
	assign lines_c     = LINES_W'((last0_c && (e0 != '0)) ? e0 : s0)
		+ (lead0_en_c  ? LINES_W'(lead0)  : LINES_W'(0))
		+ (trail0_en_c ? LINES_W'(trail0) : LINES_W'(0));
	assign pql_c       = (OVL_W+M_OV_W)'(lead1)  * (OVL_W+M_OV_W)'(M_OV);
	assign pqt_c       = (OVL_W+M_OV_W)'(trail1) * (OVL_W+M_OV_W)'(M_OV);

	logic [LINES_W-1:0] lines_s4;
	logic               last1_s4, lead0_en_s4, lead1_en_s4, trail1_en_s4;
	logic [32:0]        pa_s4;
	logic [31:0]        pb_s4;
	logic [35:0]        pl_s4;
	logic [31:0]        p12_s4;
	logic [OVL_W-1:0]   ql_s4, qt_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			lines_s4     <= lines_c;
			last1_s4     <= last1_c;
			lead0_en_s4  <= lead0_en_c;
			lead1_en_s4  <= lead1_en_c;
			trail1_en_s4 <= trail1_en_c;
			pa_s4        <= 33'(idx0) * 33'(s0);
			pb_s4        <= 32'(idx1) * 32'(s1);
			pl_s4        <= 36'(lead0) * 36'(st0);
			p12_s4       <= 32'(s1) * 32'(s2);
			ql_s4        <= pql_c[K_OV+OVL_W-1:K_OV];
			qt_s4        <= pqt_c[K_OV+OVL_W-1:K_OV];
		end
	end

	// stage five: offset products, overlap rounding, base line length
	logic [OVL_W+ALN_W-1:0] qal_c, qat_c;
	logic [RND_W-1:0]       rl_c, rt_c;

	assign qal_c = (OVL_W+ALN_W)'(ql_s4) * (OVL_W+ALN_W)'(ALN);
	assign qat_c = (OVL_W+ALN_W)'(qt_s4) * (OVL_W+ALN_W)'(ALN);
	assign rl_c  = RND_W'(qal_c + ((qal_c != (OVL_W+ALN_W)'(lead1))
		? (OVL_W+ALN_W)'(ALN) : (OVL_W+ALN_W)'(0)));
	assign rt_c  = RND_W'(qat_c + ((qat_c != (OVL_W+ALN_W)'(trail1))
		? (OVL_W+ALN_W)'(ALN) : (OVL_W+ALN_W)'(0)));

	logic [LINES_W-1:0] lines_s5;
	logic               lead1_en_s5, trail1_en_s5;
	logic [56:0]        oa_s5;
	logic [55:0]        ob_s5;
	logic [RND_W-1:0]   rl_s5, rt_s5;
	logic [31:0]        base_s5;
	logic [35:0]        plm_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			lines_s5     <= lines_s4;
			lead1_en_s5  <= lead1_en_s4;
			trail1_en_s5 <= trail1_en_s4;
			oa_s5        <= 57'(pa_s4) * 57'(st0);
			ob_s5        <= 56'(pb_s4) * 56'(st1);
			rl_s5        <= rl_c;
			rt_s5        <= rt_c;
			// in fold mode the dim1 edge size replaces the whole folded line
			base_s5      <= (last1_s4 && (e1 != '0)) ? 32'(e1) : (fold ? p12_s4 : 32'(s1));
			plm_s5       <= lead0_en_s4 ? pl_s4 : 36'd0;
		end
	end

	// stage six: unrounded line length and total subtracted elements
	logic [LINES_W-1:0] lines_s6;
	logic [56:0]        oa_s6;
	logic [55:0]        ob_s6;
	logic [LP_W-1:0]    lp_s6;
	logic [36:0]        sub_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			lines_s6 <= lines_s5;
			oa_s6    <= oa_s5;
			ob_s6    <= ob_s5;
			lp_s6    <= LP_W'(base_s5) + LP_W'(shift)
				+ (lead1_en_s5  ? LP_W'(rl_s5) : LP_W'(0))
				+ (trail1_en_s5 ? LP_W'(rt_s5) : LP_W'(0));
			sub_s6   <= 37'(plm_s5) + 37'(shift)
				+ (lead1_en_s5 ? 37'(rl_s5) : 37'd0);
		end
	end

	// stage seven: offset sum in elements, fold of the line length residue
	logic signed [59:0] osum_c;

	assign osum_c = $signed({3'b000, oa_s6}) + $signed({4'b0000, ob_s6})
		- $signed({23'd0, sub_s6});

	logic [LINES_W-1:0] lines_s7;
	logic [LP_W-1:0]    lp_s7;
	logic [XF_W-1:0]    xf_s7;
	logic signed [61:0] off_s7;

	always_ff @(posedge clk) begin
		if (en7) begin
			lines_s7 <= lines_s6;
			lp_s7    <= lp_s6;
			xf_s7    <= XF_W'(lp_s6[LP_W-1:16]) * XF_W'(C16) + XF_W'(lp_s6[15:0]);
			off_s7   <= {osum_c, 2'b00};  // four bytes per element
		end
	end

	// stage eight: residue quotient, offset saturation
	logic [XF_W+M_XF_W-1:0] pqf_c;
	logic [OFF_W-1:0]       osat_c;

	assign pqf_c  = (XF_W+M_XF_W)'(xf_s7) * (XF_W+M_XF_W)'(M_XF);
	assign osat_c = ((&off_s7[61:31]) || !(|off_s7[61:31])) ? off_s7[31:0]
		: (off_s7[61] ? OFF_MIN : OFF_MAX);

	logic [LINES_W-1:0] lines_s8;
	logic [LP_W-1:0]    lp_s8;
	logic [XF_W-1:0]    xf_s8, qf_s8;
	logic [OFF_W-1:0]   off_s8;

	always_ff @(posedge clk) begin
		if (en8) begin
			lines_s8 <= lines_s7;
			lp_s8    <= lp_s7;
			xf_s8    <= xf_s7;
			qf_s8    <= pqf_c[K_XF+XF_W-1:K_XF];
			off_s8   <= osat_c;
		end
	end

	// stage nine: pad to the alignment, clamp, output register
	logic [XF_W-1:0]   resid_c;
	logic [ALN_W-1:0]  pad_c;
	logic [LP_W:0]     len_c;

	assign resid_c = xf_s8 - XF_W'(qf_s8) * XF_W'(ALN);
	assign pad_c   = (resid_c == '0) ? ALN_W'(0) : ALN - ALN_W'(resid_c);
	assign len_c   = (LP_W+1)'(lp_s8) + (LP_W+1)'(pad_c);

	logic [LINES_W-1:0] lines_s9;
	logic [LEN_W-1:0]   len_s9;
	logic [OFF_W-1:0]   off_s9;

	always_ff @(posedge clk) begin
		if (en9) begin
			lines_s9 <= lines_s8;
			len_s9   <= (len_c > (LP_W+1)'(LEN_MAX)) ? LEN_MAX : len_c[LEN_W-1:0];
			off_s9   <= off_s8;
		end
	end

	assign win.valid       = v_s9;
	assign win.line_count  = lines_s9;
	assign win.line_length = len_s9;
	assign win.byte_offset = $signed(off_s9);

`ifndef SYNTHESIS
	// column index from the divider stays below the column chunk count
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld |-> (div_res.rem < n1e))
		else $error("divider remainder not below divisor");

	// reciprocal quotient leaves a residue below the alignment
	a_resid: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> (resid_c < XF_W'(ALN)))
		else $error("line length residue out of range");

	// a waiting result is not overwritten by the stage behind it
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s9 && !win.ready) |=> (v_s9 && $stable(len_s9) && $stable(off_s9)))
		else $error("stalled window changed");
`endif

endmodule

`default_nettype wire
